// ===== design/rpa_pkg.sv =====
// rpa_pkg: constants, opcode and status codes, and controller/datapath
// command and status structs for the refcounted page allocator
// no dependencies
package rpa_pkg;

    // geometry
    localparam int NUM_PAGES  = 1024;
    localparam int PAGE_BYTES = 4096;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int PAGE_W     = $clog2(NUM_PAGES);
    localparam int DEPTH_W    = $clog2(NUM_PAGES + 1);

    // field widths
    localparam int OP_W     = 3;
    localparam int ADDR_W   = 23;
    localparam int IDX_W    = ADDR_W - PAGE_SHIFT;
    localparam int STATUS_W = 3;
    localparam int PA_W     = 22;
    localparam int REF_W    = 16;
    localparam int FREE_W   = 11;

    localparam logic [REF_W-1:0] REF_MAX = {REF_W{1'b1}};

    // opcodes
    localparam logic [OP_W-1:0] OP_INIT  = 3'd0;
    localparam logic [OP_W-1:0] OP_ALLOC = 3'd1;
    localparam logic [OP_W-1:0] OP_FREE  = 3'd2;
    localparam logic [OP_W-1:0] OP_INC   = 3'd3;
    localparam logic [OP_W-1:0] OP_QUERY = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_SHARED    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_OOM       = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BADADDR   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd4;
    localparam logic [STATUS_W-1:0] ST_OUTRANGE  = 3'd5;
    localparam logic [STATUS_W-1:0] ST_SAT       = 3'd6;

    // controller to datapath
    typedef struct packed {
        logic capture;     // transaction accepted: latch request, issue reads
        logic execute;     // perform the operation and load the result
        logic sweep_load;  // start init sweep at first free page, empty stack
        logic sweep_step;  // zero one count and advance the sweep pointer
        logic sweep_push;  // push the swept page onto the stack
    } rpa_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;    // result register can take a new result
        logic op_init;     // latched opcode is init
        logic sweep_last;  // sweep pointer is at the last page
    } rpa_sts_t;

endpackage

// ===== design/rpa_req_if.sv =====
// rpa_req_if: request channel (opcode and byte address) with valid/ready
// depends on rpa_pkg
interface rpa_req_if import rpa_pkg::*;;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   opcode;
    logic [ADDR_W-1:0] phys_addr;

    modport source (output valid, output opcode, output phys_addr, input ready);
    modport sink   (input valid, input opcode, input phys_addr, output ready);
endinterface

// ===== design/rpa_rsp_if.sv =====
// rpa_rsp_if: result channel (status, page address, count, free pages)
// depends on rpa_pkg
interface rpa_rsp_if import rpa_pkg::*;;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [PA_W-1:0]     page_addr;
    logic [REF_W-1:0]    ref_value;
    logic [FREE_W-1:0]   free_pages;

    modport source (output valid, output status, output page_addr,
                    output ref_value, output free_pages, input ready);
    modport sink   (input valid, input status, input page_addr,
                    input ref_value, input free_pages, output ready);
endinterface

// ===== design/rpa_ctrl.sv =====
// rpa_ctrl: controller state machine for the page allocator
// depends on rpa_pkg; drives rpa_datapath through rpa_cmd_t
module rpa_ctrl import rpa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  rpa_sts_t  sts,
    output rpa_cmd_t  cmd
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_EXEC  = 3'd2;
    localparam logic [2:0] S_INIT  = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // state register, clearing pass runs first after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.capture    = in_valid && (state_reg == S_IDLE);
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.sweep_step = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (sts.op_init)
                begin
                    cmd.sweep_load = 1'b1;
                    state_next     = S_INIT;
                end
                else if (sts.out_free)
                begin
                    cmd.execute = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_INIT:
            begin
                cmd.sweep_step = 1'b1;
                cmd.sweep_push = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.execute = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== design/rpa_datapath.sv =====
// rpa_datapath: count memory, free stack memory, stack depth, sweep pointer
// and result register; depends on rpa_pkg, commanded by rpa_ctrl
module rpa_datapath import rpa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [PAGE_W-1:0]   cfg_wdata,
    input  logic [OP_W-1:0]     in_opcode,
    input  logic [ADDR_W-1:0]   in_phys_addr,
    input  rpa_cmd_t            cmd,
    output rpa_sts_t            sts,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [STATUS_W-1:0] out_status,
    output logic [PA_W-1:0]     out_page_addr,
    output logic [REF_W-1:0]    out_ref_value,
    output logic [FREE_W-1:0]   out_free_pages
);

    logic [REF_W-1:0]  ref_mem [NUM_PAGES];
    logic [PAGE_W-1:0] stk_mem [NUM_PAGES];

    logic [PAGE_W-1:0]   ffp_reg;
    logic [DEPTH_W-1:0]  depth_reg;
    logic [DEPTH_W-1:0]  depth_next;
    logic [PAGE_W-1:0]   sweep_reg;
    logic [OP_W-1:0]     op_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [REF_W-1:0]    ref_rd_reg;
    logic [PAGE_W-1:0]   stk_rd_reg;
    logic                out_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [PA_W-1:0]     page_addr_reg;
    logic [REF_W-1:0]    ref_value_reg;
    logic [FREE_W-1:0]   free_pages_reg;

    logic [PAGE_W-1:0]   rd_idx;
    logic [PAGE_W-1:0]   pop_idx;
    logic [IDX_W-1:0]    idx_full;
    logic [PAGE_W-1:0]   idx;
    logic                in_range;
    logic                misaligned;
    logic                below_ffp;
    logic                stack_empty;
    logic                stack_full;
    logic [REF_W-1:0]    ref_dec;
    logic [REF_W-1:0]    ref_inc;

    logic                ref_we;
    logic [PAGE_W-1:0]   ref_waddr;
    logic [REF_W-1:0]    ref_wdata;
    logic                stk_we;
    logic [PAGE_W-1:0]   stk_waddr;
    logic [PAGE_W-1:0]   stk_wdata;
    logic [STATUS_W-1:0] res_status;
    logic [PA_W-1:0]     res_page_addr;
    logic [REF_W-1:0]    res_ref_value;

    // read addresses at accept: page of the request and top of stack
    assign rd_idx  = in_phys_addr[PAGE_SHIFT +: PAGE_W];
    assign pop_idx = PAGE_W'(depth_reg - DEPTH_W'(1));

    // decode of the latched address
    assign idx_full    = addr_reg[ADDR_W-1:PAGE_SHIFT];
    assign idx         = idx_full[PAGE_W-1:0];
    assign in_range    = (idx_full < IDX_W'(NUM_PAGES));
    assign misaligned  = (addr_reg[PAGE_SHIFT-1:0] != '0);
    assign below_ffp   = (idx_full < IDX_W'(ffp_reg));
    assign stack_empty = (depth_reg == '0);
    assign stack_full  = (depth_reg == DEPTH_W'(NUM_PAGES));
    assign ref_dec     = ref_rd_reg - REF_W'(1);
    assign ref_inc     = ref_rd_reg + REF_W'(1);

    // count memory
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            ref_rd_reg <= ref_mem[rd_idx];
        end
        if (ref_we)
        begin
            ref_mem[ref_waddr] <= ref_wdata;
        end
    end

    // free stack memory
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            stk_rd_reg <= stk_mem[pop_idx];
        end
        if (stk_we)
        begin
            stk_mem[stk_waddr] <= stk_wdata;
        end
    end

    // request latch
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= in_opcode;
            addr_reg <= in_phys_addr;
        end
    end

    // operation and sweep logic
    always_comb
    begin
        depth_next    = depth_reg;
        ref_we        = 1'b0;
        ref_waddr     = idx;
        ref_wdata     = '0;
        stk_we        = 1'b0;
        stk_waddr     = depth_reg[PAGE_W-1:0];
        stk_wdata     = idx;
        res_status    = ST_OK;
        res_page_addr = '0;
        res_ref_value = '0;

        if (cmd.sweep_step)
        begin
            ref_we    = 1'b1;
            ref_waddr = sweep_reg;
            ref_wdata = '0;
            if (cmd.sweep_push)
            begin
                stk_we     = 1'b1;
                stk_wdata  = sweep_reg;
                depth_next = depth_reg + DEPTH_W'(1);
            end
        end

        if (cmd.execute)
        begin
            case (op_reg)
                OP_ALLOC:
                begin
                    if (stack_empty)
                    begin
                        res_status = ST_OOM;
                    end
                    else
                    begin
                        depth_next    = depth_reg - DEPTH_W'(1);
                        ref_we        = 1'b1;
                        ref_waddr     = stk_rd_reg;
                        ref_wdata     = REF_W'(1);
                        res_ref_value = REF_W'(1);
                        res_page_addr = PA_W'({stk_rd_reg, {PAGE_SHIFT{1'b0}}});
                    end
                end
                OP_FREE:
                begin
                    if (misaligned || below_ffp)
                    begin
                        res_status = ST_BADADDR;
                    end
                    else if (!in_range)
                    begin
                        res_status = ST_OUTRANGE;
                    end
                    else if (ref_rd_reg == '0)
                    begin
                        res_status = ST_UNDERFLOW;
                    end
                    else
                    begin
                        ref_we        = 1'b1;
                        ref_wdata     = ref_dec;
                        res_ref_value = ref_dec;
                        if (ref_dec != '0)
                        begin
                            res_status = ST_SHARED;
                        end
                        else if (!stack_full)
                        begin
                            // last reference gone, page goes back on the stack unless the stack is full
                            stk_we     = 1'b1;
                            depth_next = depth_reg + DEPTH_W'(1);
                        end
                    end
                end
                OP_INC:
                begin
                    if (!in_range)
                    begin
                        res_status = ST_OUTRANGE;
                    end
                    else if (ref_rd_reg == REF_MAX)
                    begin
                        res_status    = ST_SAT;
                        res_ref_value = REF_MAX;
                    end
                    else
                    begin
                        ref_we        = 1'b1;
                        ref_wdata     = ref_inc;
                        res_ref_value = ref_inc;
                    end
                end
                OP_QUERY:
                begin
                    if (!in_range)
                    begin
                        res_status = ST_OUTRANGE;
                    end
                    else
                    begin
                        res_ref_value = ref_rd_reg;
                    end
                end
                default:
                begin
                    // init result and unused opcodes change nothing
                end
            endcase
        end
    end

    // configuration, stack depth and sweep pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ffp_reg   <= '0;
            depth_reg <= '0;
            sweep_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                ffp_reg <= cfg_wdata;
            end
            if (cmd.sweep_load)
            begin
                depth_reg <= '0;
                sweep_reg <= ffp_reg;
            end
            else
            begin
                depth_reg <= depth_next;
                if (cmd.sweep_step)
                begin
                    sweep_reg <= sweep_reg + PAGE_W'(1);
                end
            end
        end
    end

    // result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.execute)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (cmd.execute)
        begin
            status_reg     <= res_status;
            page_addr_reg  <= res_page_addr;
            ref_value_reg  <= res_ref_value;
            free_pages_reg <= FREE_W'(depth_next);
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_status     = status_reg;
    assign out_page_addr  = page_addr_reg;
    assign out_ref_value  = ref_value_reg;
    assign out_free_pages = free_pages_reg;

    assign sts.out_free   = !out_valid_reg || out_ready;
    assign sts.op_init    = (op_reg == OP_INIT);
    assign sts.sweep_last = (sweep_reg == PAGE_W'(NUM_PAGES - 1));

endmodule

// ===== design/refcounted_page_allocator_core.sv =====
// refcounted_page_allocator_core: top level of the refcounted page allocator
// depends on rpa_pkg, rpa_req_if, rpa_rsp_if, rpa_ctrl, rpa_datapath
//
//  channel  direction  handshake      payload
//  req      in         valid / ready  opcode, phys_addr
//  rsp      out        valid / ready  status, page_addr, ref_value, free_pages
//  cfg      in         cfg_we         cfg_wdata = first_free_page
//
// alloc, free, inc and query read the count and stack memories at accept
// and write them back in the execute state once the result register is free.
// init sweeps one page a cycle from first_free_page up to the last page.
// after reset a clearing pass zeroes all 1024 counts, one a cycle,
// before the first request is taken. a stalled rsp holds the next result in
// the execute state; a new request is taken while a result waits.
module refcounted_page_allocator_core import rpa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [PAGE_W-1:0] cfg_wdata,
    rpa_req_if.sink           req,
    rpa_rsp_if.source         rsp
);

    rpa_cmd_t cmd;
    rpa_sts_t sts;

    // controller
    rpa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath
    rpa_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_opcode      (req.opcode),
        .in_phys_addr   (req.phys_addr),
        .cmd            (cmd),
        .sts            (sts),
        .out_valid      (rsp.valid),
        .out_ready      (rsp.ready),
        .out_status     (rsp.status),
        .out_page_addr  (rsp.page_addr),
        .out_ref_value  (rsp.ref_value),
        .out_free_pages (rsp.free_pages)
    );

endmodule

// ===== tb/tb_refcounted_page_allocator_core.sv =====
// tb_refcounted_page_allocator_core: self-checking testbench for the page allocator core
// a directed table, then random phases checked against a predictor
// depends on rpa_pkg, rpa_req_if, rpa_rsp_if and refcounted_page_allocator_core
module tb_refcounted_page_allocator_core;
    import rpa_pkg::*;

    localparam int WATCHDOG_LIMIT  = 20000;
    localparam int RX_HOLD_CYCLES  = 400;
    localparam int CFG_SETTLE      = 8;
    localparam int END_SETTLE      = 40;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 175;
    localparam int DIRECTED_ROWS   = 27;

    // opcodes the block ignores
    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PA_W-1:0]     page_addr;
        logic [REF_W-1:0]    ref_value;
        logic [FREE_W-1:0]   free_pages;
    } alloc_result_t;

    typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;
    typedef enum int {IDLE_NONE, IDLE_TX, IDLE_RX, IDLE_BOTH} idle_mode_e;

    // one directed row; for ROW_CFG the addr field holds the new first free page
    typedef struct packed {
        row_kind_e           kind;
        logic [OP_W-1:0]     op;
        logic [ADDR_W-1:0]   addr;
        logic                fixed;
        logic [STATUS_W-1:0] w_status;
        logic [PA_W-1:0]     w_page;
        logic [REF_W-1:0]    w_ref;
        logic [FREE_W-1:0]   w_free;
    } stim_row_t;

    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        // straight after reset: empty stack, all counts zero
        '{ROW_REQ, OP_ALLOC,    23'h000000, 1'b1, ST_OOM,       22'h0,      16'd0, 11'd0},
        '{ROW_REQ, OP_QUERY,    23'h000000, 1'b1, ST_OK,        22'h0,      16'd0, 11'd0},
        '{ROW_REQ, OP_QUERY,    23'h7FFFFF, 1'b1, ST_OUTRANGE,  22'h0,      16'd0, 11'd0},
        '{ROW_REQ, OP_FREE,     23'h000000, 1'b1, ST_UNDERFLOW, 22'h0,      16'd0, 11'd0},
        '{ROW_REQ, OP_FREE,     23'h000001, 1'b1, ST_BADADDR,   22'h0,      16'd0, 11'd0},
        '{ROW_REQ, OP_FREE,     23'h400000, 1'b1, ST_OUTRANGE,  22'h0,      16'd0, 11'd0},
        '{ROW_REQ, OP_INC,      23'h7FFFFF, 1'b1, ST_OUTRANGE,  22'h0,      16'd0, 11'd0},
        '{ROW_REQ, OP_INC,      23'h000000, 1'b1, ST_OK,        22'h0,      16'd1, 11'd0},
        '{ROW_REQ, OP_SPARE_LO, 23'h7FFFFF, 1'b1, ST_OK,        22'h0,      16'd0, 11'd0},
        '{ROW_REQ, OP_SPARE_HI, 23'h000000, 1'b1, ST_OK,        22'h0,      16'd0, 11'd0},
        // four managed pages, page 0 keeps its count below the kernel end
        '{ROW_CFG, OP_INIT,     23'd1020,   1'b0, ST_OK,        22'h0,      16'd0, 11'd0},
        '{ROW_REQ, OP_INIT,     23'h000000, 1'b1, ST_OK,        22'h0,      16'd0, 11'd4},
        '{ROW_REQ, OP_ALLOC,    23'h000000, 1'b1, ST_OK,        22'h3FF000, 16'd1, 11'd3},
        '{ROW_REQ, OP_FREE,     23'h000000, 1'b1, ST_BADADDR,   22'h0,      16'd0, 11'd3},
        '{ROW_REQ, OP_QUERY,    23'h000000, 1'b1, ST_OK,        22'h0,      16'd1, 11'd3},
        '{ROW_REQ, OP_ALLOC,    23'h000000, 1'b0, ST_OK,        22'h0,      16'd0, 11'd0},
        '{ROW_REQ, OP_ALLOC,    23'h000000, 1'b0, ST_OK,        22'h0,      16'd0, 11'd0},
        '{ROW_REQ, OP_ALLOC,    23'h000000, 1'b1, ST_OK,        22'h3FC000, 16'd1, 11'd0},
        '{ROW_REQ, OP_ALLOC,    23'h000000, 1'b1, ST_OOM,       22'h0,      16'd0, 11'd0},
        '{ROW_REQ, OP_INC,      23'h3FF000, 1'b1, ST_OK,        22'h0,      16'd2, 11'd0},
        '{ROW_REQ, OP_FREE,     23'h3FF000, 1'b1, ST_SHARED,    22'h0,      16'd1, 11'd0},
        '{ROW_REQ, OP_FREE,     23'h3FF000, 1'b0, ST_OK,        22'h0,      16'd0, 11'd0},
        // every page managed: a free to zero on a full stack drops the push
        '{ROW_CFG, OP_INIT,     23'd0,      1'b0, ST_OK,        22'h0,      16'd0, 11'd0},
        '{ROW_REQ, OP_INIT,     23'h000000, 1'b1, ST_OK,        22'h0,      16'd0, 11'd1024},
        '{ROW_REQ, OP_INC,      23'h005000, 1'b0, ST_OK,        22'h0,      16'd0, 11'd0},
        '{ROW_REQ, OP_FREE,     23'h005000, 1'b1, ST_OK,        22'h0,      16'd0, 11'd1024},
        '{ROW_REQ, OP_ALLOC,    23'h000000, 1'b1, ST_OK,        22'h3FF000, 16'd1, 11'd1023}
    };

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [PAGE_W-1:0] cfg_wdata;

    rpa_req_if req_ch ();
    rpa_rsp_if rsp_ch ();

    refcounted_page_allocator_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // predictor state
    logic [REF_W-1:0]   ref_count  [NUM_PAGES];
    logic [PAGE_W-1:0]  free_stack [NUM_PAGES];
    logic [DEPTH_W-1:0] stack_depth;
    logic [PAGE_W-1:0]  first_page;

    alloc_result_t awaited_outcomes [$];
    idle_mode_e    idle_mode;
    int            error_count;
    int            results_checked;
    int            requests_sent;
    int            config_writes;
    int            hold_requests;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // predict one transaction and update the predictor state
    function automatic alloc_result_t page_op_outcome(input logic [OP_W-1:0] op,
                                                      input logic [ADDR_W-1:0] addr);
        alloc_result_t     r;
        logic [IDX_W-1:0]  idx;
        logic [PAGE_W-1:0] pg;
        int                p;
        r        = '0;
        r.status = ST_OK;
        idx      = addr[ADDR_W-1:PAGE_SHIFT];
        pg       = idx[PAGE_W-1:0];
        case (op)
            OP_INIT:
            begin
                stack_depth = '0;
                for (p = first_page; p < NUM_PAGES; p++)
                begin
                    ref_count[p] = '0;
                    if (stack_depth < NUM_PAGES)
                    begin
                        free_stack[stack_depth] = p[PAGE_W-1:0];
                        stack_depth++;
                    end
                end
            end
            OP_ALLOC:
            begin
                if (stack_depth == 0)
                    r.status = ST_OOM;
                else
                begin
                    stack_depth--;
                    pg            = free_stack[stack_depth];
                    ref_count[pg] = 16'd1;
                    r.ref_value   = 16'd1;
                    r.page_addr   = {pg, {PAGE_SHIFT{1'b0}}};
                end
            end
            OP_FREE:
            begin
                if (addr[PAGE_SHIFT-1:0] != 0 || idx < first_page)
                    r.status = ST_BADADDR;
                else if (idx >= NUM_PAGES)
                    r.status = ST_OUTRANGE;
                else if (ref_count[pg] == 0)
                    r.status = ST_UNDERFLOW;
                else
                begin
                    ref_count[pg]--;
                    r.ref_value = ref_count[pg];
                    if (r.ref_value != 0)
                        r.status = ST_SHARED;
                    else if (stack_depth < NUM_PAGES)
                    begin
                        free_stack[stack_depth] = pg;
                        stack_depth++;
                    end
                end
            end
            OP_INC:
            begin
                if (idx >= NUM_PAGES)
                    r.status = ST_OUTRANGE;
                else
                begin
                    if (ref_count[pg] == REF_MAX)
                        r.status = ST_SAT;
                    else
                        ref_count[pg]++;
                    r.ref_value = ref_count[pg];
                end
            end
            OP_QUERY:
            begin
                if (idx >= NUM_PAGES)
                    r.status = ST_OUTRANGE;
                else
                    r.ref_value = ref_count[pg];
            end
            default:
            begin
            end
        endcase
        r.free_pages = stack_depth;
        return r;
    endfunction

    function automatic bit tx_gap();
        case (idle_mode)
            IDLE_TX:   return $urandom_range(99) < 67;
            IDLE_BOTH: return $urandom_range(99) < 20;
            default:   return 1'b0;
        endcase
    endfunction

    function automatic bit rx_stall();
        case (idle_mode)
            IDLE_RX:   return $urandom_range(99) < 67;
            IDLE_BOTH: return $urandom_range(99) < 20;
            default:   return 1'b0;
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endfunction

    // offer one request, record its outcome once accepted
    task automatic send_req(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                            input logic fixed, input alloc_result_t given,
                            output alloc_result_t got);
        while (tx_gap())
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.opcode    <= op;
        req_ch.phys_addr <= addr;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        got = page_op_outcome(op, addr);
        awaited_outcomes.push_back(fixed ? given : got);
        requests_sent++;
    endtask

    task automatic drain_outcomes();
        req_ch.valid <= 1'b0;
        while (awaited_outcomes.size() != 0)
            @(posedge clk);
    endtask

    // register write only once the block has gone quiet
    task automatic set_first_page(input logic [PAGE_W-1:0] value);
        drain_outcomes();
        repeat (CFG_SETTLE) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we     <= 1'b0;
        first_page  = value;
        config_writes++;
    endtask

    // receiver: random stalls plus an occasional long hold-off
    initial
    begin
        int hold_seen;
        int hold_left;
        hold_seen    = 0;
        hold_left    = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_seen != hold_requests)
            begin
                hold_seen = hold_requests;
                hold_left = RX_HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= !rx_stall();
        end
    end

    // result checker
    always @(posedge clk)
    begin
        alloc_result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (awaited_outcomes.size() == 0)
            begin
                $display("%0t: result with no transaction outstanding", $time);
                error_count++;
            end
            else
            begin
                want = awaited_outcomes.pop_front();
                check_field("status", want.status, rsp_ch.status);
                check_field("page_addr", want.page_addr, rsp_ch.page_addr);
                check_field("ref_value", want.ref_value, rsp_ch.ref_value);
                check_field("free_pages", want.free_pages, rsp_ch.free_pages);
                results_checked++;
            end
        end
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge clk)
    begin
        int quiet;
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        stim_row_t          row;
        alloc_result_t      got;
        logic [OP_W-1:0]    op;
        logic [ADDR_W-1:0]  addr;
        logic [PA_W-1:0]    live_pages [$];
        logic [PAGE_W-1:0]  phase_page;
        int                 phase;
        int                 n;
        int                 k;
        int                 roll;

        error_count      = 0;
        results_checked  = 0;
        requests_sent    = 0;
        config_writes    = 0;
        hold_requests    = 0;
        idle_mode        = IDLE_BOTH;
        stack_depth      = '0;
        first_page       = '0;
        for (k = 0; k < NUM_PAGES; k++)
            ref_count[k] = '0;

        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_wdata        = '0;
        req_ch.valid     = 1'b0;
        req_ch.opcode    = OP_INIT;
        req_ch.phys_addr = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed table
        for (k = 0; k < DIRECTED_ROWS; k++)
        begin
            row = directed_rows[k];
            if (row.kind == ROW_CFG)
                set_first_page(row.addr[PAGE_W-1:0]);
            else
                send_req(row.op, row.addr, row.fixed,
                         {row.w_status, row.w_page, row.w_ref, row.w_free}, got);
        end

        // random phases over several kernel ends and idling patterns
        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0, 6:    phase_page = 10'd0;
                1:       phase_page = 10'd1023;
                2:       phase_page = 10'd1000;
                4:       phase_page = 10'd1016;
                7:       phase_page = 10'd1008;
                default: phase_page = PAGE_W'($urandom_range(1023));
            endcase
            set_first_page(phase_page);
            idle_mode = idle_mode_e'(phase % 4);
            live_pages.delete();
            send_req(OP_INIT, '0, 1'b0, '0, got);
            // long receiver hold-off while the sender keeps offering
            if (phase == 4)
                hold_requests++;
            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (phase == 5 && n == ITEMS_PER_PHASE / 2)
                    drain_outcomes();
                roll = $urandom_range(99);
                addr = {1'b0, PAGE_W'($urandom_range(1023)), {PAGE_SHIFT{1'b0}}};
                if (roll < 3)
                    op = OP_INIT;
                else if (roll < 30)
                    op = OP_ALLOC;
                else if (roll < 55)
                begin
                    op = OP_FREE;
                    if (live_pages.size() != 0)
                    begin
                        k    = $urandom_range(live_pages.size() - 1);
                        addr = {1'b0, live_pages[k]};
                        live_pages.delete(k);
                    end
                end
                else if (roll < 68)
                begin
                    op = OP_INC;
                    if (live_pages.size() != 0)
                        addr = {1'b0, live_pages[$urandom_range(live_pages.size() - 1)]};
                end
                else if (roll < 80)
                begin
                    op = OP_QUERY;
                    if ($urandom_range(1))
                        addr[PAGE_SHIFT-1:0] = PAGE_SHIFT'($urandom());
                end
                else
                begin
                    // noise: any opcode, any address, half of them page aligned
                    op   = OP_W'($urandom_range(7));
                    addr = ADDR_W'($urandom());
                    if ($urandom_range(1))
                        addr[PAGE_SHIFT-1:0] = '0;
                end
                send_req(op, addr, 1'b0, '0, got);
                if (op == OP_INIT)
                    live_pages.delete();
                else if (op == OP_ALLOC && got.status == ST_OK)
                    live_pages.push_back(got.page_addr);
            end
        end

        drain_outcomes();
        repeat (END_SETTLE) @(posedge clk);

        $display("checked %0d results for %0d requests under %0d kernel-end settings",
                 results_checked, requests_sent, config_writes);
        $display("covered full and empty stacks, address errors, underflow, all idling patterns");
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
